[hw/rtl/rpn_pkg.sv]
// Shared types and constants for the RPN fixed-point stack calculator.
// Holds command and status codes, transfer payload structs and ALU handshake structs.
// No dependencies.
package rpn_pkg;

	localparam int VAL_W           = 13;
	localparam int MAG_W           = 12;
	localparam int FRAC_W          = 4;
	localparam int CMD_W           = 3;
	localparam int DEPTH_W         = 8;
	localparam int STACK_DEPTH_DEF = 128;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_POW  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_FEW  = 2'd2,
		ST_DIV0 = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] push_value;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   pushed_value;
		logic [DEPTH_W-1:0] stack_depth;
	} rsp_item_t;

	typedef struct packed {
		logic             start;
		cmd_t             op;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             done;
		logic             div_zero;
		logic [VAL_W-1:0] value;
	} alu_rsp_t;

endpackage

[hw/rtl/rpn_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rpn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/rpn_alu.sv]
// Sign-magnitude Q8.4 arithmetic unit: add, subtract and multiply,
// 16-step restoring divide, 8-step square-and-multiply power mod 256.
// Depends on rpn_pkg.
module rpn_alu import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int DIV_STEPS = 2 * MAG_W - 2 * FRAC_W;
	localparam int POW_STEPS = MAG_W - FRAC_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int DVD_W     = MAG_W + FRAC_W;
	localparam int INT_W     = MAG_W - FRAC_W;

	logic             busy_q;
	logic             done_q;
	cmd_t             op_q;
	logic [CNT_W-1:0] step_q;
	logic             dz_q;
	logic             sx_q;
	logic [VAL_W-1:0] res_q;
	logic [DVD_W-1:0] dvd_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] dvs_q;
	logic [INT_W-1:0] acc_q;
	logic [INT_W-1:0] sq_q;
	logic [INT_W-1:0] exp_q;

	logic [MAG_W-1:0]   ma;
	logic [MAG_W-1:0]   mb;
	logic               sx;
	logic [2*MAG_W-1:0] prod;
	logic [MAG_W-1:0]   sum;
	logic [MAG_W-1:0]   diff;
	logic [MAG_W:0]     trial;
	logic [MAG_W:0]     trial_sub;
	logic               ge;
	logic [MAG_W-1:0]   rem_nxt;
	logic [2*INT_W-1:0] acc_mul;
	logic [2*INT_W-1:0] sq_sq;
	logic [INT_W-1:0]   acc_fin;
	logic               last;

	assign ma   = req.a[MAG_W-1:0];
	assign mb   = req.b[MAG_W-1:0];
	assign sx   = req.a[VAL_W-1] ^ req.b[VAL_W-1];
	assign prod = {{MAG_W{1'b0}}, ma} * {{MAG_W{1'b0}}, mb};
	assign sum  = ma + mb;
	assign diff = ma - mb;

	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = trial >= {1'b0, dvs_q};
	assign rem_nxt   = ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];

	assign acc_mul = {{INT_W{1'b0}}, acc_q} * {{INT_W{1'b0}}, sq_q};
	assign sq_sq   = {{INT_W{1'b0}}, sq_q} * {{INT_W{1'b0}}, sq_q};
	assign acc_fin = exp_q[0] ? acc_mul[INT_W-1:0] : acc_q;

	assign last = (op_q == CMD_DIV) ? (step_q == CNT_W'(DIV_STEPS - 1))
	                                : (step_q == CNT_W'(POW_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= CMD_PUSH;
			step_q <= '0;
		end else if (req.start) begin
			op_q   <= req.op;
			step_q <= '0;
			if ((req.op == CMD_DIV && mb != '0) || req.op == CMD_POW) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (busy_q) begin
			step_q <= step_q + CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dz_q <= 1'b0;
			unique case (req.op)
				CMD_ADD: begin
					res_q <= {1'b0, sum};
				end
				CMD_SUB: begin
					res_q <= {1'b0, diff};
				end
				CMD_MUL: begin
					res_q <= {sx, prod[MAG_W+FRAC_W-1:FRAC_W]};
				end
				CMD_DIV: begin
					dz_q  <= (mb == '0);
					res_q <= {sx, {MAG_W{1'b0}}};
					sx_q  <= sx;
					dvd_q <= {ma, {FRAC_W{1'b0}}};
					rem_q <= '0;
					dvs_q <= mb;
				end
				CMD_POW: begin
					acc_q <= INT_W'(1);
					sq_q  <= ma[MAG_W-1:FRAC_W];
					exp_q <= mb[MAG_W-1:FRAC_W];
				end
				default: begin
					res_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			if (op_q == CMD_DIV) begin
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				rem_q <= rem_nxt;
				if (last) begin
					res_q <= {sx_q, dvd_q[MAG_W-2:0], ge};
				end
			end else begin
				acc_q <= acc_fin;
				sq_q  <= sq_sq[INT_W-1:0];
				exp_q <= exp_q >> 1;
				if (last) begin
					res_q <= {1'b0, acc_fin, {FRAC_W{1'b0}}};
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign rsp.value    = res_q;

endmodule

[hw/rtl/rpn_fixed_point_stack_calculator.sv]
// Flow, accept to result: push, no-op, full-stack and too-few-operand items go straight
// to the done state; operator items read both operands and wait for the ALU, which
// iterates for divide by a nonzero divisor and for power. One item in flight; the next
// is taken once the result is committed to the output register; commit waits on stalls.
// Reset clears the entry count and handshake state; stack contents stay undefined.
module rpn_fixed_point_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int EXT_W  = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  new_cnt_q;
	logic [CNT_W-1:0]  cnt_p1;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic [EXT_W-1:0]  cnt_ext;
	logic [CMD_W-1:0]  cmd_q;
	status_t           status_q;
	logic [VAL_W-1:0]  val_q;
	logic              wr_q;
	logic [ADDR_W-1:0] waddr_q;
	logic [VAL_W-1:0]  b_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	logic              accept;
	logic              commit;
	logic              out_free;
	logic              is_push;
	logic              is_op;
	logic              full;
	logic              few;
	logic [ADDR_W-1:0] raddr;
	logic [VAL_W-1:0]  rdata;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign cnt_p1  = count_q + CNT_W'(1);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_m2  = count_q - CNT_W'(2);
	assign full    = (count_q == CNT_W'(STACK_DEPTH));
	assign few     = (count_q < CNT_W'(2));
	assign cnt_ext = EXT_W'(new_cnt_q);

	assign is_push = (req.cmd == CMD_PUSH);
	always_comb begin
		unique case (cmd_t'(req.cmd))
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW: is_op = 1'b1;
			default: is_op = 1'b0;
		endcase
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign accept   = req_valid && !req_stall;
	assign commit   = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		raddr     = cnt_m1[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = (is_op && !few) ? S_RD_B : S_DONE;
				end
			end
			S_RD_B: begin
				raddr   = cnt_m2[ADDR_W-1:0];
				state_d = S_RD_A;
			end
			S_RD_A: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (alu_rsp.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Stack writes only land at commit, after all reads of the item, so no overlap.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			if (is_push) begin
				if (full) begin
					status_q  <= ST_FULL;
					val_q     <= '0;
					wr_q      <= 1'b0;
					new_cnt_q <= count_q;
				end else begin
					status_q  <= ST_OK;
					val_q     <= req.push_value;
					wr_q      <= 1'b1;
					waddr_q   <= count_q[ADDR_W-1:0];
					new_cnt_q <= cnt_p1;
				end
			end else if (is_op) begin
				if (few) begin
					status_q  <= ST_FEW;
					val_q     <= '0;
					wr_q      <= 1'b0;
					new_cnt_q <= count_q;
				end else begin
					wr_q      <= 1'b1;
					waddr_q   <= cnt_m2[ADDR_W-1:0];
					new_cnt_q <= cnt_m1;
				end
			end else begin
				status_q  <= ST_OK;
				val_q     <= '0;
				wr_q      <= 1'b0;
				new_cnt_q <= count_q;
			end
		end
		if (state_q == S_RD_B) begin
			b_q <= rdata;
		end
		if (state_q == S_EXEC && alu_rsp.done) begin
			val_q    <= alu_rsp.value;
			status_q <= alu_rsp.div_zero ? ST_DIV0 : ST_OK;
		end
		if (commit) begin
			rsp_q.status       <= status_q;
			rsp_q.pushed_value <= val_q;
			rsp_q.stack_depth  <= cnt_ext[DEPTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= new_cnt_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	rpn_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (commit && wr_q),
		.waddr (waddr_q),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign alu_req.start = (state_q == S_RD_A);
	assign alu_req.op    = cmd_t'(cmd_q);
	assign alu_req.a     = rdata;
	assign alu_req.b     = b_q;

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
